// File: hw/rtl/cce_pkg.sv
// Shared constants, codes and types for the clock counter eviction cache.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cce_pkg;

    // Default sizing, used as the defaults of the top level parameters
    localparam int CCE_CAPACITY = 64;
    localparam int CCE_KEY_BITS = 32;

    // Fixed field widths
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;
    localparam int CNT_W      = 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_COUNT_CAP = 1'b0;
    localparam logic [CNT_W-1:0] COUNT_CAP_RESET = 8'd3;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ACCESS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PIN    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNPIN  = 3'd5;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT   = 3'd5;

    // Storage strobes from the sequencer to the slot store
    typedef struct packed {
        logic key_rd;
        logic key_we;
        logic cnt_rd;
        logic cnt_we;
    } t_mem_ctl;

endpackage

// File: hw/rtl/cce_req_if.sv
// Request channel: valid/ready handshake carrying mode, key and pin slot.
// Depends on cce_pkg for the field widths.
`timescale 1ns / 1ps

interface cce_req_if import cce_pkg::*; #(
    parameter int KEY_BITS = CCE_KEY_BITS
);
    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [KEY_BITS-1:0]   key;
    logic [SLOT_OUT_W-1:0] pin_slot;

    modport source (output valid, output mode, output key, output pin_slot, input ready);
    modport sink   (input valid, input mode, input key, input pin_slot, output ready);
endinterface

// File: hw/rtl/cce_rsp_if.sv
// Response channel: valid/ready handshake carrying status and slot.
// Depends on cce_pkg for the field widths.
`timescale 1ns / 1ps

interface cce_rsp_if import cce_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

// File: hw/rtl/clock_counter_eviction_cache_top.sv
// Channel  | Dir | Handshake   | Payload
// i_req    | in  | valid/ready | mode[2:0], key[KEY_BITS-1:0], pin_slot[5:0]
// o_rsp    | out | valid/ready | status[2:0], slot[5:0]
// APB      | in  | psel/penable| paddr[2:0], pwdata[31:0] -> count_cap at address 0
//
// One request at a time under a small sequencer around one shared slot store.
// Search: one key read per cycle until a match or the last resident slot.
// Counter bump: counter read, then write. A sweep step skips a pinned slot;
// on an unpinned one it does a counter read, then a decrement or replace.
// Synchronous active-low reset; no clearing pass. A finished result waits in
// the output register while the next request is taken.
// Depends on cce_pkg, cce_req_if, cce_rsp_if and cce_store.
`timescale 1ns / 1ps

module clock_counter_eviction_cache_top import cce_pkg::*; #(
    parameter int CAPACITY = CCE_CAPACITY,
    parameter int KEY_BITS = CCE_KEY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cce_req_if.sink               i_req,
    cce_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_BUMP_RD = 3'd2;
    localparam logic [2:0] S_BUMP_WR = 3'd3;
    localparam logic [2:0] S_INSERT  = 3'd4;
    localparam logic [2:0] S_SW_RD   = 3'd5;
    localparam logic [2:0] S_SW_CHK  = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0]            r_state,   n_state;
    logic [MODE_W-1:0]     r_mode,    n_mode;
    logic [KEY_BITS-1:0]   r_key,     n_key;
    logic [CW-1:0]         r_idx,     n_idx;
    logic                  r_rd_vld,  n_rd_vld;
    logic [SW-1:0]         r_rd_idx,  n_rd_idx;
    logic [SW-1:0]         r_slot,    n_slot;
    logic [STATUS_W-1:0]   r_status,  n_status;
    logic [CW-1:0]         r_res_cnt, n_res_cnt;
    logic [CW-1:0]         r_pin_cnt, n_pin_cnt;
    logic [CAPACITY-1:0]   r_pinned,  n_pinned;
    logic [SW-1:0]         r_hand,    n_hand;
    logic [CNT_W-1:0]      r_cap;
    logic                  r_out_vld, n_out_vld;
    logic [STATUS_W-1:0]   r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;

    t_mem_ctl              mem_ctl;
    logic [SW-1:0]         rd_addr;
    logic [SW-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [CNT_W-1:0]      wr_cnt;
    logic [KEY_BITS-1:0]   rd_key;
    logic [CNT_W-1:0]      rd_cnt;

    logic                  issue;
    logic                  match;
    logic                  ps_ok;
    logic [SW-1:0]         ps_idx;
    logic [SW-1:0]         hand_next;
    logic                  load_out;
    logic                  cfg_wr;

    cce_store #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_cnt  (wr_cnt),
        .o_rd_key  (rd_key),
        .o_rd_cnt  (rd_cnt)
    );

    // Configuration port: single register, zero-wait
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_COUNT_CAP);
    assign prdata = (paddr[2] == REG_COUNT_CAP) ? APB_DATA_W'(r_cap) : '0;

    // Handshake outputs
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

    // Shared helpers
    assign hand_next = (r_hand == SW'(CAPACITY - 1)) ? '0 : r_hand + SW'(1);
    assign ps_idx    = SW'(i_req.pin_slot);
    assign ps_ok     = (32'(i_req.pin_slot) < 32'(r_res_cnt))
                    && (32'(i_req.pin_slot) < 32'(CAPACITY));
    assign issue     = (r_idx < r_res_cnt);
    assign match     = r_rd_vld && (rd_key == r_key);
    assign load_out  = (r_state == S_RESP) && (!r_out_vld || o_rsp.ready);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_rd_idx  = r_idx[SW-1:0];
        n_slot    = r_slot;
        n_status  = r_status;
        n_res_cnt = r_res_cnt;
        n_pin_cnt = r_pin_cnt;
        n_pinned  = r_pinned;
        n_hand    = r_hand;
        mem_ctl   = '0;
        rd_addr   = r_idx[SW-1:0];
        wr_addr   = r_hand;
        wr_key    = r_key;
        wr_cnt    = CNT_W'(1);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode = i_req.mode;
                    n_key  = i_req.key;
                    n_slot = '0;
                    case (i_req.mode)
                        MODE_ACCESS, MODE_LOOKUP, MODE_PEEK: begin
                            n_idx   = '0;
                            n_state = S_SEARCH;
                        end
                        MODE_INSERT: begin
                            n_state = S_INSERT;
                        end
                        MODE_PIN: begin
                            if (ps_ok) begin
                                if (!r_pinned[ps_idx]) begin
                                    n_pin_cnt = r_pin_cnt + CW'(1);
                                end
                                n_pinned[ps_idx] = 1'b1;
                                n_status         = ST_DONE;
                            end else begin
                                n_status = ST_BAD_SLOT;
                            end
                            n_state = S_RESP;
                        end
                        MODE_UNPIN: begin
                            n_pinned  = '0;
                            n_pin_cnt = '0;
                            n_status  = ST_DONE;
                            n_state   = S_RESP;
                        end
                        default: begin
                            n_status = ST_DONE;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // Stream key reads, compare each key in the cycle after its read
                mem_ctl.key_rd = issue;
                n_rd_vld       = issue;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (match) begin
                    n_rd_vld = 1'b0;
                    n_slot   = r_rd_idx;
                    n_status = ST_HIT;
                    n_state  = (r_mode == MODE_PEEK) ? S_RESP : S_BUMP_RD;
                end else if (!issue) begin
                    if (r_mode == MODE_ACCESS) begin
                        n_state = S_INSERT;
                    end else begin
                        n_slot   = '0;
                        n_status = ST_ABSENT;
                        n_state  = S_RESP;
                    end
                end
            end
            S_BUMP_RD: begin
                rd_addr        = r_slot;
                mem_ctl.cnt_rd = 1'b1;
                n_state        = S_BUMP_WR;
            end
            S_BUMP_WR: begin
                // Saturate at the configured cap
                wr_addr = r_slot;
                wr_cnt  = rd_cnt + CNT_W'(1);
                if (rd_cnt < r_cap) begin
                    mem_ctl.cnt_we = 1'b1;
                end
                n_state = S_RESP;
            end
            S_INSERT: begin
                if (r_res_cnt < CW'(CAPACITY)) begin
                    // Fill the next free slot
                    wr_addr        = r_res_cnt[SW-1:0];
                    mem_ctl.key_we = 1'b1;
                    mem_ctl.cnt_we = 1'b1;
                    n_slot         = r_res_cnt[SW-1:0];
                    n_res_cnt      = r_res_cnt + CW'(1);
                    n_status       = ST_INSERTED;
                    n_state        = S_RESP;
                end else if (r_pin_cnt == CW'(CAPACITY)) begin
                    n_slot   = '0;
                    n_status = ST_ALL_PINNED;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_SW_RD;
                end
            end
            S_SW_RD: begin
                // Skip pinned slots, else fetch the counter under the hand
                if (r_pinned[r_hand]) begin
                    n_hand = hand_next;
                end else begin
                    rd_addr        = r_hand;
                    mem_ctl.cnt_rd = 1'b1;
                    n_state        = S_SW_CHK;
                end
            end
            S_SW_CHK: begin
                n_hand         = hand_next;
                mem_ctl.cnt_we = 1'b1;
                if (rd_cnt != '0) begin
                    wr_cnt  = rd_cnt - CNT_W'(1);
                    n_state = S_SW_RD;
                end else begin
                    // Evict and take over this slot
                    mem_ctl.key_we = 1'b1;
                    n_slot         = r_hand;
                    n_status       = ST_INSERTED;
                    n_state        = S_RESP;
                end
            end
            S_RESP: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: hold until taken, reload from the result state
    always_comb begin
        n_out_vld = r_out_vld && !o_rsp.ready;
        if (load_out) begin
            n_out_vld = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_res_cnt <= '0;
            r_pin_cnt <= '0;
            r_pinned  <= '0;
            r_hand    <= '0;
            r_cap     <= COUNT_CAP_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_res_cnt <= n_res_cnt;
            r_pin_cnt <= n_pin_cnt;
            r_pinned  <= n_pinned;
            r_hand    <= n_hand;
            r_out_vld <= n_out_vld;
            if (cfg_wr) begin
                r_cap <= pwdata[CNT_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_slot   <= n_slot;
        r_status <= n_status;
        if (load_out) begin
            r_out_status <= r_status;
            r_out_slot   <= SLOT_OUT_W'(r_slot);
        end
    end

    // Pin count tracks the pin bits
    a_pin_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pin_cnt) == $countones(r_pinned))
        else $error("pin count out of step with pin bits");

    // Resident count never passes capacity
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_res_cnt) <= 32'(CAPACITY))
        else $error("resident count above capacity");

    // The sweep only runs on a full table
    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_RD || r_state == S_SW_CHK) |-> (r_res_cnt == CW'(CAPACITY)))
        else $error("sweep on a table that is not full");

    // A new result appears only after the result state
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_RESP))
        else $error("result raised outside the result state");

    // No request taken during a search or a sweep check step
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_SW_CHK) |-> !i_req.ready)
        else $error("request taken mid-operation");

endmodule

// File: hw/rtl/cce_store.sv
// Slot store: key memory and frequency counter memory, one read and one
// write port each, registered read data. Depends on cce_pkg.
`timescale 1ns / 1ps

module cce_store import cce_pkg::*; #(
    parameter int CAPACITY = CCE_CAPACITY,
    parameter int KEY_BITS = CCE_KEY_BITS
) (
    input  logic                                     i_clk,
    input  t_mem_ctl                                 i_ctl,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] i_rd_addr,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] i_wr_addr,
    input  logic [KEY_BITS-1:0]                      i_wr_key,
    input  logic [CNT_W-1:0]                         i_wr_cnt,
    output logic [KEY_BITS-1:0]                      o_rd_key,
    output logic [CNT_W-1:0]                         o_rd_cnt
);

    logic [KEY_BITS-1:0] r_keys [CAPACITY];
    logic [CNT_W-1:0]    r_cnts [CAPACITY];
    logic [KEY_BITS-1:0] r_rd_key;
    logic [CNT_W-1:0]    r_rd_cnt;

    // Key memory: write on strobe, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            r_keys[i_wr_addr] <= i_wr_key;
        end
        if (i_ctl.key_rd) begin
            r_rd_key <= r_keys[i_rd_addr];
        end
    end

    // Counter memory: write on strobe, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.cnt_we) begin
            r_cnts[i_wr_addr] <= i_wr_cnt;
        end
        if (i_ctl.cnt_rd) begin
            r_rd_cnt <= r_cnts[i_rd_addr];
        end
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_cnt = r_rd_cnt;

endmodule
